// ===== hw/rtl/rmst_pkg.sv =====
// Shared types and constants for the range maximum segment tree.
// Transaction structs for the input and result channels, command codes, defaults.
// No dependencies.
package rmst_pkg;

  localparam int DEF_MAX_ELEMENTS = 1024;
  localparam int DEF_VALUE_WIDTH  = 32;

  localparam int COUNT_W = 11;
  localparam int INDEX_W = 10;
  localparam int DATA_W  = 32;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1024;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic                     command;
    logic [INDEX_W-1:0]       element_index;
    logic signed [DATA_W-1:0] element_value;
    logic [INDEX_W-1:0]       range_low;
    logic [INDEX_W-1:0]       range_high;
  } rmst_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_maximum;
    logic                     range_invalid;
  } rmst_out_t;

endpackage

// ===== hw/rtl/range_max_segment_tree_top.sv =====
// Range maximum segment tree: top level with control sequencer and node memory.
// Depends on rmst_pkg (types, codes, defaults) and rmst_ram (node store).
//
// Usage:
//   The input channel (in_valid / in_stall / in_data) carries two kinds of
//   transaction. A load writes element_value into leaf element_index and
//   refreshes every ancestor up to the root; it produces no result. A query
//   returns the maximum over [range_low, range_high] on the result channel
//   (out_valid / out_stall / out_data), with range_invalid set and a zero
//   maximum when the clipped range holds no element.
//   The tree lives in one node RAM of 2*MAX_ELEMENTS entries, one read and one
//   write per cycle. A load writes the leaf, then one parent per level up to
//   the root, with the sibling read in the same cycle as each write. A query
//   walks the tree in two steps per level (Q_LO, Q_HI), since each level may
//   need both a left and a right node read on the single port; it enters from
//   IDLE and leaves through Q_OUT, where the result is written out.
//   One transaction is in the sequencer at a time; in_stall is high while busy.
//   The next one is taken once the sequencer is back in idle, so a new load
//   or query waits until the last one is through.
//   After reset the node RAM is swept to the most negative value, one entry a
//   cycle across all 2*MAX_ELEMENTS entries, with in_stall high; cfg writes are taken.
//   element_count resets to 1024. A finished result waits in the output
//   register while out_stall is high; the next transaction is still accepted,
//   and a second query holds in its last step until the register frees up.
module range_max_segment_tree_top
  import rmst_pkg::*;
#(
  parameter int MAX_ELEMENTS = DEF_MAX_ELEMENTS,
  parameter int VALUE_WIDTH  = DEF_VALUE_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  rmst_in_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rmst_out_t          out_data,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data
);

  localparam int DEPTH = 2 * MAX_ELEMENTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = AW + 1;
  localparam int CW    = ($clog2(MAX_ELEMENTS + 1) > COUNT_W) ?
                         $clog2(MAX_ELEMENTS + 1) : COUNT_W;
  localparam int XW    = (VALUE_WIDTH > DATA_W) ? VALUE_WIDTH : DATA_W;

  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  typedef enum logic [2:0] {
    CLEAR, IDLE, L_LEAF, L_UP, Q_LO, Q_HI, Q_OUT
  } state_t;

  state_t                        state;
  logic [COUNT_W-1:0]            element_count;
  logic [AW-1:0]                 clr_addr;
  logic [NW-1:0]                 node;
  logic [NW-1:0]                 r;
  logic signed [VALUE_WIDTH-1:0] cur_val;
  logic signed [VALUE_WIDTH-1:0] best;
  logic                          q_pend;
  logic                          q_invalid;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [VALUE_WIDTH-1:0]        ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [VALUE_WIDTH-1:0]        ram_rdata;
  logic signed [VALUE_WIDTH-1:0] rd_val;

  logic [CW-1:0]                 live;
  logic [CW-1:0]                 count_x;
  logic [CW-1:0]                 hi_c;
  logic                          q_empty;
  logic                          load_ok;
  logic [NW-1:0]                 leaf;
  logic [NW-1:0]                 l_init;
  logic [NW-1:0]                 r_init;
  logic signed [XW-1:0]          val_x;
  logic signed [VALUE_WIDTH-1:0] val_sat;
  logic [NW-1:0]                 parent;
  logic signed [VALUE_WIDTH-1:0] up_max;
  logic signed [VALUE_WIDTH-1:0] best_in;
  logic                          q_rd;

  assign rd_val   = signed'(ram_rdata);
  assign in_stall = (state != IDLE);

  rmst_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_node_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Decode of an incoming transaction against the live element count
  always_comb begin
    count_x = CW'(element_count);
    live    = (count_x > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : count_x;
    load_ok = CW'(in_data.element_index) < live;
    leaf    = NW'(MAX_ELEMENTS) + NW'(in_data.element_index);
    q_empty = (in_data.range_low > in_data.range_high) ||
              (CW'(in_data.range_low) >= live);
    hi_c    = (CW'(in_data.range_high) > live - CW'(1)) ? live - CW'(1)
                                                        : CW'(in_data.range_high);
    l_init  = NW'(MAX_ELEMENTS) + NW'(in_data.range_low);
    r_init  = NW'(MAX_ELEMENTS) + NW'(hi_c) + NW'(1);
    // saturate the loaded value to the stored width
    val_x   = XW'(in_data.element_value);
    if (val_x < XW'(VMIN)) begin
      val_sat = VMIN;
    end else if (val_x > XW'(VMAX)) begin
      val_sat = VMAX;
    end else begin
      val_sat = VALUE_WIDTH'(val_x);
    end
  end

  always_comb begin
    parent  = node >> 1;
    up_max  = (rd_val > cur_val) ? rd_val : cur_val;
    // start every query from the most negative value
    best_in = (state == IDLE) ? VMIN :
              ((q_pend && (rd_val > best)) ? rd_val : best);
  end

  // Node RAM access per sequencer step
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    q_rd      = 1'b0;
    unique case (state)
      CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = VMIN;
      end
      L_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = node[AW-1:0];
        ram_wdata = cur_val;
        ram_re    = 1'b1;
        ram_raddr = node[AW-1:0] ^ AW'(1);
      end
      L_UP: begin
        // sibling data is in rdata; write parent, fetch the parent's sibling
        ram_we    = 1'b1;
        ram_waddr = parent[AW-1:0];
        ram_wdata = up_max;
        ram_re    = (parent != NW'(1));
        ram_raddr = parent[AW-1:0] ^ AW'(1);
      end
      Q_LO: begin
        q_rd      = (node < r) && node[0];
        ram_re    = q_rd;
        ram_raddr = node[AW-1:0];
      end
      Q_HI: begin
        q_rd      = r[0];
        ram_re    = q_rd;
        ram_raddr = r[AW-1:0] - AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= CLEAR;
      clr_addr      <= '0;
      element_count <= COUNT_RESET;
      out_valid     <= 1'b0;
      q_pend        <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        element_count <= cfg_wr_data;
      end
      if (out_valid && !out_stall && (state != Q_OUT)) begin
        out_valid <= 1'b0;
      end
      q_pend <= q_rd;
      best   <= best_in;
      unique case (state)
        CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (in_valid) begin
            if (in_data.command == CMD_LOAD) begin
              // drop loads past the element count
              if (load_ok) begin
                node    <= leaf;
                cur_val <= val_sat;
                state   <= L_LEAF;
              end
            end else begin
              if (q_empty) begin
                q_invalid <= 1'b1;
                state     <= Q_OUT;
              end else begin
                q_invalid <= 1'b0;
                node      <= l_init;
                r         <= r_init;
                state     <= Q_LO;
              end
            end
          end
        end
        L_LEAF: begin
          state <= L_UP;
        end
        L_UP: begin
          cur_val <= up_max;
          node    <= parent;
          if (parent == NW'(1)) begin
            state <= IDLE;
          end
        end
        Q_LO: begin
          state <= (node < r) ? Q_HI : Q_OUT;
        end
        Q_HI: begin
          node  <= (node + NW'(node[0])) >> 1;
          r     <= r >> 1;
          state <= Q_LO;
        end
        Q_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid               <= 1'b1;
            out_data.range_invalid  <= q_invalid;
            out_data.range_maximum  <= q_invalid ? '0 : DATA_W'(best);
            state                   <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  a_result_from_query: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == Q_OUT))
    else $error("result appeared without a finished query");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.range_invalid |-> out_data.range_maximum == '0)
    else $error("invalid result carries a nonzero maximum");

  a_query_bounds: assert property (@(posedge clk) disable iff (rst)
    state == Q_HI |-> node < r)
    else $error("query walk crossed its bounds");

  a_clear_after_reset: assert property (@(posedge clk)
    $past(rst) && !rst |-> in_stall)
    else $error("input accepted before node store clear");

endmodule

// ===== hw/rtl/rmst_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module rmst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for range_max_segment_tree_top: loads and range-max queries.
// Mirrors the element array, predicts each query result, checks results in order.
// Depends on rmst_pkg and the range_max_segment_tree_top RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rmst_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LONG_HOLD     = 400;

  localparam logic signed [DATA_W-1:0] VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  rmst_in_t           in_data     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  rmst_out_t          out_data;
  logic               cfg_wr_en   = 1'b0;
  logic [COUNT_W-1:0] cfg_wr_data = '0;

  // Mirror of the element array and the count register
  logic signed [DATA_W-1:0] element_mirror [DEF_MAX_ELEMENTS];
  logic [COUNT_W-1:0]       element_count_setting;
  rmst_out_t                pending_maxima[$];

  int unsigned mismatch_count   = 0;
  int unsigned cycle_count      = 0;
  int unsigned long_hold_cycles = 0;
  bit          gap_random       = 1'b0;
  bit          stall_random     = 1'b0;

  range_max_segment_tree_top dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int unsigned live_elements();
    return (element_count_setting > DEF_MAX_ELEMENTS) ? DEF_MAX_ELEMENTS
                                                       : element_count_setting;
  endfunction

  // Apply one accepted transaction to the mirror; queue the maximum a query yields
  function automatic void mirror_command(rmst_in_t t);
    int unsigned              live;
    int unsigned              top;
    int unsigned              i;
    logic signed [DATA_W-1:0] best;
    rmst_out_t                r;
    live = live_elements();
    if (t.command == CMD_LOAD) begin
      if (t.element_index < live) element_mirror[t.element_index] = t.element_value;
    end else begin
      if (t.range_low > t.range_high || t.range_low >= live) begin
        r.range_maximum = '0;
        r.range_invalid = 1'b1;
      end else begin
        // clip the upper bound to the live element count
        top  = (t.range_high > live - 1) ? live - 1 : 32'(t.range_high);
        best = VALUE_MIN;
        for (i = 32'(t.range_low); i <= top; i++) begin
          if (element_mirror[INDEX_W'(i)] > best) best = element_mirror[INDEX_W'(i)];
        end
        r.range_maximum = best;
        r.range_invalid = 1'b0;
      end
      pending_maxima.push_back(r);
    end
  endfunction

  always @(posedge clk) begin : check_results
    rmst_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_maxima.size() == 0) begin
        $display("%0t: result with none expected: maximum %0d invalid %0b", $time,
                 out_data.range_maximum, out_data.range_invalid);
        mismatch_count++;
      end else begin
        want = pending_maxima.pop_front();
        if (out_data.range_maximum !== want.range_maximum) begin
          $display("%0t: range_maximum expected %0d actual %0d", $time,
                   want.range_maximum, out_data.range_maximum);
          mismatch_count++;
        end
        if (out_data.range_invalid !== want.range_invalid) begin
          $display("%0t: range_invalid expected %0b actual %0b", $time,
                   want.range_invalid, out_data.range_invalid);
          mismatch_count++;
        end
      end
    end
  end

  // Result side: random hold-offs per result, plus one long hold on request
  initial begin : drive_out_stall
    int unsigned wait_n;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (long_hold_cycles) @(negedge clk);
        long_hold_cycles = 0;
      end else if ($urandom_range(0, 1) == 1) begin
        // sometimes start the hold-off only once a result shows up
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
      end
      wait_n = stall_random ? $urandom_range(0, 9) : 0;
      if (wait_n > 0) begin
        out_stall <= 1'b1;
        repeat (wait_n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      @(negedge clk);
    end
  end

  // Offer one transaction and hold it until accepted; returns at a falling edge
  task automatic send_item(rmst_in_t t);
    int unsigned gap;
    gap = gap_random ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    do @(posedge clk); while (in_stall);
    mirror_command(t);
    @(negedge clk);
  endtask

  task automatic send_load(int unsigned idx, logic signed [DATA_W-1:0] value);
    rmst_in_t t;
    t.command       = CMD_LOAD;
    t.element_index = INDEX_W'(idx);
    t.element_value = value;
    t.range_low     = INDEX_W'($urandom_range(0, 1023));
    t.range_high    = INDEX_W'($urandom_range(0, 1023));
    send_item(t);
  endtask

  task automatic send_query(int unsigned lo, int unsigned hi);
    rmst_in_t t;
    t.command       = CMD_QUERY;
    t.element_index = INDEX_W'($urandom_range(0, 1023));
    t.element_value = $urandom;
    t.range_low     = INDEX_W'(lo);
    t.range_high    = INDEX_W'(hi);
    send_item(t);
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_until_idle(int unsigned margin);
    in_valid <= 1'b0;
    while (pending_maxima.size() != 0) @(posedge clk);
    repeat (margin) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_element_count(logic [COUNT_W-1:0] n);
    wait_until_idle(SETTLE_CYCLES);
    cfg_wr_en             <= 1'b1;
    cfg_wr_data           <= n;
    element_count_setting  = n;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 7))
      0:       return VALUE_MAX;
      1:       return VALUE_MIN;
      2, 3:    return int'($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed loads and ranges inside the live count, some noise
  function automatic rmst_in_t random_command(int unsigned live);
    rmst_in_t    t;
    int unsigned pick;
    int unsigned lo;
    t.command       = ($urandom_range(0, 9) < 4) ? CMD_LOAD : CMD_QUERY;
    t.element_index = INDEX_W'($urandom_range(0, 1023));
    t.element_value = random_value();
    t.range_low     = INDEX_W'($urandom_range(0, 1023));
    t.range_high    = INDEX_W'($urandom_range(0, 1023));
    pick            = $urandom_range(0, 19);
    if (live > 0 && pick < 17) begin
      if (t.command == CMD_LOAD) begin
        t.element_index = INDEX_W'($urandom_range(0, live - 1));
      end else begin
        lo          = $urandom_range(0, live - 1);
        t.range_low = INDEX_W'(lo);
        if (pick < 8) begin
          t.range_high = INDEX_W'($urandom_range(lo, (lo + 15 < live) ? lo + 15 : live - 1));
        end else if (pick < 14) begin
          t.range_high = INDEX_W'($urandom_range(lo, live - 1));
        end else begin
          t.range_high = INDEX_W'($urandom_range(lo, 1023));
        end
      end
    end
    return t;
  endfunction

  task automatic test_empty_tree();
    gap_random   = 1'b0;
    stall_random = 1'b0;
    send_query(0, 1023);
    send_query(5, 5);
    send_query(7, 3);
  endtask

  task automatic test_load_extremes();
    send_load(0, VALUE_MAX);
    send_load(1023, VALUE_MIN);
    send_load(512, -1);
    send_load(511, 0);
    send_query(0, 0);
    send_query(1, 1023);
    send_query(1023, 1023);
    send_query(512, 1023);
    send_query(0, 1023);
    // overwrite the largest element
    send_load(0, VALUE_MIN);
    send_query(0, 1023);
  endtask

  task automatic test_count_limits();
    write_element_count(11'd1);
    send_load(1, 5);
    send_load(0, 7);
    send_query(0, 1023);
    send_query(1, 1);
    write_element_count(11'd0);
    send_load(0, 9);
    send_query(0, 0);
    write_element_count(11'd2047);
    send_load(1023, VALUE_MAX);
    send_query(1000, 1023);
    send_query(0, 1023);
    write_element_count(COUNT_RESET);
  endtask

  // Hold results off long enough that the block backs up into its input
  task automatic test_backpressure();
    int unsigned k;
    wait_until_idle(SETTLE_CYCLES);
    gap_random       = 1'b0;
    stall_random     = 1'b0;
    long_hold_cycles = LONG_HOLD;
    for (k = 0; k < 20; k++) begin
      send_query($urandom_range(0, 511), $urandom_range(512, 1023));
    end
    wait_until_idle(SETTLE_CYCLES);
  endtask

  task automatic test_random_phase(logic [COUNT_W-1:0] n, int unsigned items);
    int unsigned k;
    write_element_count(n);
    gap_random   = ($urandom_range(0, 3) != 0);
    stall_random = ($urandom_range(0, 3) != 0);
    for (k = 0; k < items; k++) begin
      send_item(random_command(live_elements()));
      // now and then pause the sender until every result is back
      if ($urandom_range(0, 39) == 0) wait_until_idle(0);
    end
  endtask

  initial begin : run_tests
    for (int i = 0; i < DEF_MAX_ELEMENTS; i++) element_mirror[INDEX_W'(i)] = VALUE_MIN;
    element_count_setting = COUNT_RESET;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_empty_tree();
    test_load_extremes();
    test_count_limits();
    test_backpressure();
    test_random_phase(11'd1024, 200);
    test_random_phase(11'd2047, 150);
    test_random_phase(11'd1, 60);
    test_random_phase(11'd0, 40);
    repeat (2) test_random_phase(11'($urandom_range(2, 1023)), 150);
    test_random_phase(11'($urandom_range(2, 16)), 100);
    test_random_phase(COUNT_RESET, 250);

    wait_until_idle(SETTLE_CYCLES);
    if (pending_maxima.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_maxima.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/rmst_pkg.sv
hw/rtl/rmst_ram.sv
hw/rtl/range_max_segment_tree_top.sv
tb/sv/testbench.sv
